// ===== design/smx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the stack machine executor.
// No dependencies; imported by every module of the block.
package smx_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int FRAME_DEPTH_DEF = 1024;
    localparam int CODE_BYTES_DEF  = 1024;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 5;
    localparam int CFG_W  = 10;
    localparam int STAT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        OP_ADD   = 5'd0,
        OP_NEG   = 5'd1,
        OP_MUL   = 5'd2,
        OP_DIV   = 5'd3,
        OP_MOD   = 5'd4,
        OP_EQ    = 5'd5,
        OP_GT    = 5'd6,
        OP_LT    = 5'd7,
        OP_GE    = 5'd8,
        OP_LE    = 5'd9,
        OP_AND   = 5'd10,
        OP_OR    = 5'd11,
        OP_JMP   = 5'd12,
        OP_JF    = 5'd13,
        OP_STORE = 5'd14,
        OP_LOAD  = 5'd15,
        OP_PUSH  = 5'd16,
        OP_POP   = 5'd17,
        OP_HALT  = 5'd18,
        OP_CALL  = 5'd19,
        OP_RET   = 5'd20
    } smx_op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 3'd0,
        ST_SOVF = 3'd1,
        ST_SUNF = 3'd2,
        ST_FOVF = 3'd3,
        ST_FUNF = 3'd4,
        ST_DIV0 = 3'd5
    } smx_status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the input beat
        logic exec;       // check and commit the first step
        logic opnd;       // second operand ready: commit binary op or load
        logic div_start;  // launch the divider
        logic div_fin;    // commit quotient or remainder
        logic rd_top;     // read the new top slot after a store
        logic refill;     // reload the cached top (and frame base on ret)
        logic out_load;   // fill the output register
    } smx_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic stopped;
        logic err;
        logic two_step;
        logic is_div;
        logic refill;
        logic late_read;
        logic div_done;
    } smx_stat_t;

endpackage

// ===== design/smx_div.sv =====
`timescale 1ns / 1ps
// Signed 32-bit divider, restoring, one quotient bit per cycle.
// Depends on smx_pkg for DATA_W.
module smx_div
    import smx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient,
    output logic [DATA_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] r_reg;
    logic [DATA_W-1:0] bmag_reg;
    logic              negq_reg;
    logic              negr_reg;

    logic [DATA_W:0]   r_sh;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] amag;
    logic [DATA_W-1:0] bmag;

    assign amag = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
    assign bmag = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
    assign r_sh = {r_reg, q_reg[DATA_W-1]};
    assign diff = r_sh - {1'b0, bmag_reg};

    assign done      = busy_reg && (cnt_reg == '0);
    assign quotient  = negq_reg ? (~q_reg + 1'b1) : q_reg;
    assign remainder = negr_reg ? (~r_reg + 1'b1) : r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DATA_W);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= amag;
            r_reg    <= '0;
            bmag_reg <= bmag;
            negq_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            negr_reg <= dividend[DATA_W-1];
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            // keep the shifted remainder when the trial subtract goes negative
            r_reg <= diff[DATA_W] ? r_sh[DATA_W-1:0] : diff[DATA_W-1:0];
            q_reg <= {q_reg[DATA_W-2:0], ~diff[DATA_W]};
        end
    end

endmodule

// ===== design/smx_dp.sv =====
`timescale 1ns / 1ps
// Datapath: operand stack and saved-frame memories, machine registers,
// ALU, error checks and output register. Depends on smx_pkg and smx_div.
module smx_dp
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF,
    parameter int CODE_BYTES  = CODE_BYTES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  smx_cmd_t                         cmd,
    output smx_stat_t                        stat,
    input  logic [CMD_W-1:0]                 in_cmd,
    input  logic [DATA_W-1:0]                in_imm,
    input  logic                             cfg_wr_en,
    input  logic [CFG_W-1:0]                 cfg_wr_data,
    output logic [$clog2(CODE_BYTES)-1:0]    out_pc,
    output logic [DATA_W-1:0]                out_top,
    output logic [$clog2(STACK_DEPTH+1)-1:0] out_depth,
    output logic                             out_halted,
    output logic [STAT_W-1:0]                out_status
);

    localparam int PC_W  = $clog2(CODE_BYTES);
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int FC_W  = $clog2(FRAME_DEPTH + 1);
    localparam int FA_W  = $clog2(FRAME_DEPTH);
    localparam int LOC_W = DATA_W + 2;

    logic [CMD_W-1:0]  cmd_reg;
    logic [DATA_W-1:0] imm_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [SP_W-1:0]   fb_reg;
    logic [FC_W-1:0]   fc_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [DATA_W-1:0] tos_reg;
    logic              stopped_reg;
    smx_status_t       code_reg;

    logic [DATA_W-1:0] stk_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic [SP_W-1:0]   frm_mem [FRAME_DEPTH];
    logic [SP_W-1:0]   frd_reg;

    logic [PC_W-1:0]   out_pc_reg;
    logic [DATA_W-1:0] out_top_reg;
    logic [SP_W-1:0]   out_depth_reg;
    logic              out_halted_reg;
    logic [STAT_W-1:0] out_status_reg;

    logic              is_bin;
    logic              is_divop;
    logic              has_imm;
    logic [PC_W-1:0]   seq_pc;
    logic [PC_W-1:0]   imm_pc;
    logic [DATA_W-1:0] cfg_ext;
    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;
    logic [SP_W-1:0]   sp_p1;
    logic [LOC_W-1:0]  loc;
    logic              loc_neg;
    logic              loc_hi;
    logic              sp_empty;
    logic              sp_lt2;
    logic              sp_full;
    logic              fc_full;
    logic              fc_zero;
    smx_status_t       err_code;
    logic              ok;
    logic              wr_en;
    logic [SA_W-1:0]   wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [SA_W-1:0]   rd_addr;
    logic [DATA_W-1:0] alu;
    logic [DATA_W-1:0] mul;
    logic [DATA_W-1:0] seq_ext;
    logic              div_done;
    logic [DATA_W-1:0] div_q;
    logic [DATA_W-1:0] div_r;
    logic [DATA_W-1:0] div_res;
    logic [FC_W-1:0]   fc_m1;

    // ---------------- decode and checks ----------------
    assign is_bin   = (cmd_reg <= OP_OR) && (cmd_reg != OP_NEG);
    assign is_divop = (cmd_reg == OP_DIV) || (cmd_reg == OP_MOD);
    assign has_imm  = (cmd_reg == OP_JMP) || (cmd_reg == OP_JF) || (cmd_reg == OP_STORE)
                   || (cmd_reg == OP_LOAD) || (cmd_reg == OP_PUSH) || (cmd_reg == OP_CALL);
    assign seq_pc   = pc_reg + (has_imm ? PC_W'(5) : PC_W'(1));
    assign imm_pc   = imm_reg[PC_W-1:0];
    assign seq_ext  = DATA_W'(seq_pc);
    assign cfg_ext  = DATA_W'(cfg_wr_data);

    assign sp_m1 = sp_reg - 1'b1;
    assign sp_m2 = sp_reg - SP_W'(2);
    assign sp_p1 = sp_reg + 1'b1;
    assign fc_m1 = fc_reg - 1'b1;

    assign loc     = LOC_W'(fb_reg) + {{2{imm_reg[DATA_W-1]}}, imm_reg};
    assign loc_neg = loc[LOC_W-1];
    assign loc_hi  = !loc_neg && (loc[LOC_W-2:0] >= (LOC_W-1)'(STACK_DEPTH));

    assign sp_empty = (sp_reg == '0);
    assign sp_lt2   = (sp_reg < SP_W'(2));
    assign sp_full  = (sp_reg == SP_W'(STACK_DEPTH));
    assign fc_full  = (fc_reg == FC_W'(FRAME_DEPTH));
    assign fc_zero  = (fc_reg == '0);

    always_comb
    begin
        err_code = ST_OK;
        case (cmd_reg)
            OP_ADD, OP_MUL, OP_EQ, OP_GT, OP_LT, OP_GE, OP_LE, OP_AND, OP_OR:
                if (sp_lt2) err_code = ST_SUNF;
            OP_DIV, OP_MOD:
                if (sp_lt2) err_code = ST_SUNF;
                else if (tos_reg == '0) err_code = ST_DIV0;
            OP_NEG, OP_JF, OP_POP:
                if (sp_empty) err_code = ST_SUNF;
            OP_STORE:
                if (sp_empty || loc_neg) err_code = ST_SUNF;
                else if (loc_hi) err_code = ST_SOVF;
            OP_LOAD:
                if (loc_neg) err_code = ST_SUNF;
                else if (loc_hi || sp_full) err_code = ST_SOVF;
            OP_PUSH:
                if (sp_full) err_code = ST_SOVF;
            OP_CALL:
                if (sp_full) err_code = ST_SOVF;
                else if (fc_full) err_code = ST_FOVF;
            OP_RET:
                if (sp_empty) err_code = ST_SUNF;
                else if (fc_zero) err_code = ST_FUNF;
            default:
                err_code = ST_OK;
        endcase
    end

    assign ok = !stopped_reg && (err_code == ST_OK);

    assign stat.stopped   = stopped_reg;
    assign stat.err       = (err_code != ST_OK);
    assign stat.two_step  = (is_bin && !is_divop) || (cmd_reg == OP_LOAD);
    assign stat.is_div    = is_divop;
    assign stat.refill    = (cmd_reg == OP_JF) || (cmd_reg == OP_POP) || (cmd_reg == OP_RET);
    assign stat.late_read = (cmd_reg == OP_STORE);
    assign stat.div_done  = div_done;

    // ---------------- ALU and divider ----------------
    assign mul = rdata_reg * tos_reg;

    always_comb
    begin
        case (cmd_reg)
            OP_ADD: alu = rdata_reg + tos_reg;
            OP_MUL: alu = mul;
            OP_EQ:  alu = DATA_W'(rdata_reg == tos_reg);
            OP_GT:  alu = DATA_W'($signed(rdata_reg) >  $signed(tos_reg));
            OP_LT:  alu = DATA_W'($signed(rdata_reg) <  $signed(tos_reg));
            OP_GE:  alu = DATA_W'($signed(rdata_reg) >= $signed(tos_reg));
            OP_LE:  alu = DATA_W'($signed(rdata_reg) <= $signed(tos_reg));
            OP_AND: alu = DATA_W'((rdata_reg != '0) && (tos_reg != '0));
            OP_OR:  alu = DATA_W'((rdata_reg != '0) || (tos_reg != '0));
            default: alu = rdata_reg;
        endcase
    end

    smx_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (rdata_reg),
        .divisor   (tos_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign div_res = (cmd_reg == OP_MOD) ? div_r : div_q;

    // ---------------- operand stack memory ----------------
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sp_reg[SA_W-1:0];
        wr_data = tos_reg;
        if (cmd.exec && ok)
        begin
            case (cmd_reg)
                OP_NEG:
                begin
                    wr_en   = 1'b1;
                    wr_addr = sp_m1[SA_W-1:0];
                    wr_data = '0 - tos_reg;
                end
                OP_STORE:
                begin
                    wr_en   = 1'b1;
                    wr_addr = loc[SA_W-1:0];
                end
                OP_PUSH:
                begin
                    wr_en   = 1'b1;
                    wr_data = imm_reg;
                end
                OP_CALL:
                begin
                    wr_en   = 1'b1;
                    wr_data = seq_ext;
                end
                default:
                    wr_en = 1'b0;
            endcase
        end
        else if (cmd.opnd)
        begin
            wr_en = 1'b1;
            if (cmd_reg == OP_LOAD)
                wr_data = rdata_reg;
            else
            begin
                wr_addr = sp_m2[SA_W-1:0];
                wr_data = alu;
            end
        end
        else if (cmd.div_fin)
        begin
            wr_en   = 1'b1;
            wr_addr = sp_m2[SA_W-1:0];
            wr_data = div_res;
        end
    end

    always_comb
    begin
        if (cmd.rd_top)
            rd_addr = sp_m1[SA_W-1:0];
        else if (cmd_reg == OP_LOAD)
            rd_addr = loc[SA_W-1:0];
        else
            rd_addr = sp_m2[SA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            stk_mem[wr_addr] <= wr_data;
        rdata_reg <= stk_mem[rd_addr];
    end

    // ---------------- saved frame memory ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.exec && ok && (cmd_reg == OP_CALL))
            frm_mem[fc_reg[FA_W-1:0]] <= fb_reg;
        frd_reg <= frm_mem[fc_m1[FA_W-1:0]];
    end

    // ---------------- input capture ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= in_cmd;
            imm_reg <= in_imm;
        end
    end

    // ---------------- machine registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg      <= '0;
            fb_reg      <= '0;
            fc_reg      <= '0;
            pc_reg      <= '0;
            tos_reg     <= '0;
            stopped_reg <= 1'b0;
            code_reg    <= ST_OK;
        end
        else if (cfg_wr_en)
            pc_reg <= cfg_ext[PC_W-1:0];
        else if (cmd.exec && !stopped_reg)
        begin
            if (err_code != ST_OK)
            begin
                stopped_reg <= 1'b1;
                code_reg    <= err_code;
            end
            else
            begin
                case (cmd_reg)
                    OP_ADD, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_GT, OP_LT, OP_GE,
                    OP_LE, OP_AND, OP_OR, OP_LOAD:
                        pc_reg <= pc_reg;
                    OP_NEG:
                    begin
                        tos_reg <= '0 - tos_reg;
                        pc_reg  <= seq_pc;
                    end
                    OP_JMP:
                        pc_reg <= imm_pc;
                    OP_JF:
                    begin
                        sp_reg <= sp_m1;
                        pc_reg <= (tos_reg == '0) ? imm_pc : seq_pc;
                    end
                    OP_STORE, OP_POP:
                    begin
                        sp_reg <= sp_m1;
                        pc_reg <= seq_pc;
                    end
                    OP_PUSH:
                    begin
                        sp_reg  <= sp_p1;
                        tos_reg <= imm_reg;
                        pc_reg  <= seq_pc;
                    end
                    OP_HALT:
                    begin
                        pc_reg      <= seq_pc;
                        stopped_reg <= 1'b1;
                        code_reg    <= ST_OK;
                    end
                    OP_CALL:
                    begin
                        sp_reg  <= sp_p1;
                        tos_reg <= seq_ext;
                        fc_reg  <= fc_reg + 1'b1;
                        fb_reg  <= sp_p1;
                        pc_reg  <= imm_pc;
                    end
                    OP_RET:
                    begin
                        sp_reg <= sp_m1;
                        fc_reg <= fc_m1;
                        pc_reg <= tos_reg[PC_W-1:0];
                    end
                    default:
                        pc_reg <= seq_pc;
                endcase
            end
        end
        else if (cmd.opnd)
        begin
            pc_reg <= seq_pc;
            if (cmd_reg == OP_LOAD)
            begin
                tos_reg <= rdata_reg;
                sp_reg  <= sp_p1;
            end
            else
            begin
                tos_reg <= alu;
                sp_reg  <= sp_m1;
            end
        end
        else if (cmd.div_fin)
        begin
            pc_reg  <= seq_pc;
            tos_reg <= div_res;
            sp_reg  <= sp_m1;
        end
        else if (cmd.refill)
        begin
            tos_reg <= rdata_reg;
            if (cmd_reg == OP_RET)
                fb_reg <= frd_reg;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pc_reg     <= pc_reg;
            out_top_reg    <= sp_empty ? '0 : tos_reg;
            out_depth_reg  <= sp_reg;
            out_halted_reg <= stopped_reg;
            out_status_reg <= code_reg;
        end
    end

    assign out_pc     = out_pc_reg;
    assign out_top    = out_top_reg;
    assign out_depth  = out_depth_reg;
    assign out_halted = out_halted_reg;
    assign out_status = out_status_reg;

    // ---------------- assertions ----------------
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stopped flag dropped");

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_fc_range: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FC_W'(FRAME_DEPTH))
        else $error("frame count beyond depth");

endmodule

// ===== design/smx_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences each instruction through the datapath and owns
// the stream handshakes. Depends on smx_pkg.
module smx_ctrl
    import smx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  smx_stat_t stat,
    output smx_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_OPND,
        S_DIV,
        S_RDTOP,
        S_REFILL,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.load       = (state_reg == S_IDLE) && s_tvalid;
        cmd.exec       = (state_reg == S_EXEC);
        cmd.opnd       = (state_reg == S_OPND) && !stat.is_div;
        cmd.div_start  = (state_reg == S_OPND) && stat.is_div;
        cmd.div_fin    = (state_reg == S_DIV) && stat.div_done;
        cmd.rd_top     = (state_reg == S_RDTOP);
        cmd.refill     = (state_reg == S_REFILL);
        cmd.out_load   = (state_reg == S_OUT) && out_free;

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_tvalid) state_next = S_EXEC;
            S_EXEC:
                if (stat.stopped || stat.err) state_next = S_OUT;
                else if (stat.two_step || stat.is_div) state_next = S_OPND;
                else if (stat.refill) state_next = S_REFILL;
                else if (stat.late_read) state_next = S_RDTOP;
                else state_next = S_OUT;
            S_OPND:
                state_next = stat.is_div ? S_DIV : S_OUT;
            S_DIV:
                if (stat.div_done) state_next = S_OUT;
            S_RDTOP:
                state_next = S_REFILL;
            S_REFILL:
                state_next = S_OUT;
            S_OUT:
                if (out_free) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output step");

endmodule

// ===== design/stack_machine_executor.sv =====
`timescale 1ns / 1ps
// Stack machine executor: one bytecode instruction per input beat, one result beat each.
// Steps: execute, output for jumps, push, call, halt, neg, unknown opcodes, errors and every
// beat after a stop; execute, operand read, output for binary ops and load; execute, top
// refill, output for pop, jf, ret; execute, top read, top refill, output for store; execute,
// divider start, serial divide (1 bit per cycle), output for div and mod. The next beat is
// taken once the result is in the output register. rst_n clears the stack pointer, frame base,
// frame count, stop flag and pc; stack and saved-frame memories are not cleared. Depends on all smx_ files.
module stack_machine_executor
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF,
    parameter int CODE_BYTES  = CODE_BYTES_DEF   // power of two; addresses wrap by masking
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DATA_W-1:0]  s_tdata,   // imm
    input  logic [CMD_W-1:0]   s_tuser,   // cmd
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    // next_pc, top_value, depth, halted, status, zero fill to whole bytes
    output logic [(($clog2(CODE_BYTES) + $clog2(STACK_DEPTH+1) + DATA_W + 1 + STAT_W + 7)
                   / 8) * 8 - 1:0] m_tdata,
    // configuration: entry_pc
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data
);

    localparam int PC_W  = $clog2(CODE_BYTES);
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int OUT_W = PC_W + DATA_W + SP_W + 1 + STAT_W;
    localparam int TD_W  = ((OUT_W + 7) / 8) * 8;

    smx_cmd_t          cmd;
    smx_stat_t         stat;
    logic [PC_W-1:0]   out_pc;
    logic [DATA_W-1:0] out_top;
    logic [SP_W-1:0]   out_depth;
    logic              out_halted;
    logic [STAT_W-1:0] out_status;

    // Controller: accepts a beat only when idle, then walks it through
    // execute, operand fetch, divide, top read, top refill and output steps.
    smx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: the top of stack is cached in a register and written through
    // to the stack memory, so a binary op needs only one memory read.
    smx_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAME_DEPTH (FRAME_DEPTH),
        .CODE_BYTES  (CODE_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_cmd      (s_tuser),
        .in_imm      (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_pc      (out_pc),
        .out_top     (out_top),
        .out_depth   (out_depth),
        .out_halted  (out_halted),
        .out_status  (out_status)
    );

    // Pack the result beat, lowest field first.
    assign m_tdata = TD_W'({out_status, out_halted, out_depth, out_top, out_pc});

endmodule

// ===== bench/stack_machine_executor_check.sv =====
`timescale 1ns / 1ps
// Result checker for the stack machine executor: watches the input, result and
// configuration ports, predicts every result beat and compares it. Needs smx_pkg.
module stack_machine_executor_check
    import smx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic [4:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [63:0]       m_tdata,
    input  logic              cfg_wr_en,
    input  logic [9:0]        cfg_wr_data,
    output int                mismatches,
    output int                outstanding
);

    // highest field first, so pc lands in the lowest bits as on m_tdata
    typedef struct packed {
        logic [2:0]  status;
        logic        halted;
        logic [10:0] depth;
        logic [31:0] top;
        logic [9:0]  pc;
    } vm_result_t;

    logic [31:0] slots [1024];
    logic [10:0] frames [1024];
    logic [10:0] sp, fb, fc;
    logic [9:0]  pc;
    logic        stopped;
    smx_status_t stop_code;
    vm_result_t  expected_q [$];

    assign outstanding = expected_q.size();

    task automatic execute_instr(input logic [4:0] op, input logic [31:0] imm,
                                 output vm_result_t res);
        logic [31:0] ua, ub, r;
        logic signed [31:0] a, b;
        logic [9:0]  seq;
        longint      loc;
        smx_status_t err;
        bit          has_imm;
        has_imm = op inside {OP_JMP, OP_JF, OP_STORE, OP_LOAD, OP_PUSH, OP_CALL};
        seq = pc + (has_imm ? 10'd5 : 10'd1);
        err = ST_OK;
        loc = longint'(fb) + longint'($signed(imm));
        if (!stopped) begin
            if (op <= OP_OR && op != OP_NEG) begin
                if (sp < 2) err = ST_SUNF;
                else
                begin
                    ub = slots[sp-1];
                    ua = slots[sp-2];
                    a = ua;
                    b = ub;
                    r = 0;
                    case (op)
                        OP_ADD: r = ua + ub;
                        OP_MUL: r = ua * ub;
                        OP_DIV, OP_MOD:
                            if (ub == 0) err = ST_DIV0;
                            else if (ua == 32'h8000_0000 && ub == 32'hFFFF_FFFF)
                                r = (op == OP_DIV) ? 32'h8000_0000 : 32'h0;
                            else r = (op == OP_DIV) ? a / b : a % b;
                        OP_EQ:  r = a == b;
                        OP_GT:  r = a > b;
                        OP_LT:  r = a < b;
                        OP_GE:  r = a >= b;
                        OP_LE:  r = a <= b;
                        OP_AND: r = (ua != 0) && (ub != 0);
                        default: r = (ua != 0) || (ub != 0);
                    endcase
                    if (err == ST_OK)
                    begin
                        slots[sp-2] = r;
                        sp = sp - 1;
                        pc = seq;
                    end
                end
            end
            else if (op == OP_NEG) begin
                if (sp < 1) err = ST_SUNF;
                else
                begin
                    slots[sp-1] = 32'd0 - slots[sp-1];
                    pc = seq;
                end
            end
            else if (op == OP_JMP) pc = imm[9:0];
            else if (op == OP_JF) begin
                if (sp < 1) err = ST_SUNF;
                else
                begin
                    pc = (slots[sp-1] == 0) ? imm[9:0] : seq;
                    sp = sp - 1;
                end
            end
            else if (op == OP_STORE || op == OP_LOAD) begin
                if (op == OP_STORE && sp < 1) err = ST_SUNF;
                else if (loc < 0) err = ST_SUNF;
                else if (loc >= 1024) err = ST_SOVF;
                else if (op == OP_STORE)
                begin
                    sp = sp - 1;
                    slots[loc] = slots[sp];
                    pc = seq;
                end
                else if (sp >= 1024) err = ST_SOVF;
                else
                begin
                    slots[sp] = slots[loc];
                    sp = sp + 1;
                    pc = seq;
                end
            end
            else if (op == OP_PUSH) begin
                if (sp >= 1024) err = ST_SOVF;
                else
                begin
                    slots[sp] = imm;
                    sp = sp + 1;
                    pc = seq;
                end
            end
            else if (op == OP_POP) begin
                if (sp < 1) err = ST_SUNF;
                else
                begin
                    sp = sp - 1;
                    pc = seq;
                end
            end
            else if (op == OP_HALT) begin
                pc = seq;
                stopped = 1'b1;
                stop_code = ST_OK;
            end
            else if (op == OP_CALL) begin
                if (sp >= 1024) err = ST_SOVF;
                else if (fc >= 1024) err = ST_FOVF;
                else
                begin
                    slots[sp] = {22'd0, seq};
                    sp = sp + 1;
                    frames[fc] = fb;
                    fc = fc + 1;
                    fb = sp;
                    pc = imm[9:0];
                end
            end
            else if (op == OP_RET) begin
                if (sp < 1) err = ST_SUNF;
                else if (fc == 0) err = ST_FUNF;
                else
                begin
                    sp = sp - 1;
                    pc = slots[sp][9:0];
                    fc = fc - 1;
                    fb = frames[fc];
                end
            end
            else pc = seq;   // unknown opcode: no operation
            if (err != ST_OK)
            begin
                stopped = 1'b1;
                stop_code = err;
            end
        end
        res.pc = pc;
        res.top = (sp != 0) ? slots[sp-1] : 32'd0;
        res.depth = sp;
        res.halted = stopped;
        res.status = stop_code;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        vm_result_t res, got;
        if (!rst_n)
        begin
            sp = 0;
            fb = 0;
            fc = 0;
            pc = 0;
            stopped = 1'b0;
            stop_code = ST_OK;
            mismatches <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_wr_en) pc = cfg_wr_data;
            if (s_tvalid && s_tready)
            begin
                execute_instr(s_tuser, s_tdata, res);
                expected_q.push_back(res);
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[56:0];
                if (expected_q.size() == 0)
                begin
                    if (mismatches < 10) $display("unexpected result beat %h", got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    res = expected_q.pop_front();
                    if (got !== res)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: pc %0d/%0d top %h/%h depth %0d/%0d halt %b/%b st %0d/%0d (exp/got)",
                                res.pc, got.pc, res.top, got.top, res.depth, got.depth,
                                res.halted, got.halted, res.status, got.status);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/stack_machine_executor_test.sv =====
`timescale 1ns / 1ps
// Top of the stack machine executor testbench: drives instruction beats, random
// stalls and entry_pc writes, and reports the verdict. Needs smx_pkg and the checker.
module stack_machine_executor_test;
    import smx_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // imm
    logic [4:0]  s_tuser = '0;   // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // next_pc, top_value, depth, halted, status
    logic        cfg_wr_en = 1'b0;
    logic [9:0]  cfg_wr_data = '0;
    int          mismatches, outstanding;
    int          cycles = 0;

    // Shadow of the machine kept only to steer stimulus away from errors
    // and from reads of stack slots that were never written.
    int          sp = 0, fb = 0, fc = 0;
    int          saved_fb [$];
    bit          written [1024];
    bit          burst = 0;

    stack_machine_executor dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    stack_machine_executor_check chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: draw a stall per beat, with bursts of no stall at all.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 49) == 0) burst = !burst;
            n = burst ? 0 : $urandom_range(0, 18);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Send one instruction beat and advance the shadow, assuming it succeeds.
    task automatic send_instr(input logic [4:0] op, input logic [31:0] imm);
        int n, loc;
        n = burst ? 0 : $urandom_range(0, 18);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= imm;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        loc = fb + $signed(imm);
        case (op)
            OP_NEG, OP_JMP, OP_HALT: ;
            OP_JF, OP_POP: sp--;
            OP_STORE:
            begin
                sp--;
                if (loc >= 0 && loc < 1024) written[loc] = 1;
            end
            OP_LOAD, OP_PUSH:
            begin
                if (sp < 1024) written[sp] = 1;
                sp++;
            end
            OP_CALL:
            begin
                written[sp] = 1;
                sp++;
                saved_fb.push_back(fb);
                fb = sp;
                fc++;
            end
            OP_RET:
            begin
                sp--;
                fc--;
                fb = saved_fb.pop_back();
            end
            default: if (op <= OP_OR) sp--;
        endcase
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: rand_value = $urandom_range(0, 8) - 4;
            1: rand_value = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'd0} - $urandom_range(0, 1);
            default: rand_value = $urandom;
        endcase
    endfunction

    // One random well-formed instruction (or harmless noise) given the shadow.
    task automatic random_instr();
        int k, loc;
        logic [4:0] op;
        k = $urandom_range(0, 99);
        if (sp > 200 && k < 30) k = 40;   // drain a deep stack
        if (k < 25 || sp < 2)
        begin
            if (sp < 1000) send_instr(OP_PUSH, rand_value());
            else send_instr(OP_POP, 0);
        end
        else if (k < 30) send_instr(OP_POP, 0);
        else if (k < 45)
        begin
            op = $urandom_range(OP_EQ, OP_OR);
            if ($urandom_range(0, 2) == 0) op = $urandom_range(0, 1) ? OP_ADD : OP_MUL;
            send_instr(op, 0);
        end
        else if (k < 53)
        begin
            // keep the divisor nonzero by pushing it right before
            send_instr(OP_PUSH, ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : rand_value() | 32'd1);
            send_instr($urandom_range(0, 1) ? OP_DIV : OP_MOD, 0);
        end
        else if (k < 57) send_instr(OP_NEG, 0);
        else if (k < 62) send_instr(OP_JMP, $urandom);
        else if (k < 68) send_instr(OP_JF, $urandom);
        else if (k < 75)
        begin
            loc = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(0, 1023);
            send_instr(OP_STORE, loc - fb);
        end
        else if (k < 83 && sp < 1000)
        begin
            loc = $urandom_range(0, sp - 1);
            repeat (4)
            begin
                k = $urandom_range(0, 1023);
                if (written[k]) loc = k;
            end
            send_instr(OP_LOAD, loc - fb);
        end
        else if (k < 89 && fc < 30 && sp < 1000) send_instr(OP_CALL, $urandom);
        else if (k < 95 && fc > 0) send_instr(OP_RET, 0);
        else send_instr($urandom_range(21, 31), $urandom);
    endtask

    // Write entry_pc only once the block has drained; drop the input first.
    task automatic write_entry(input logic [9:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [9:0] entries [4];
        logic [4:0] op;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        entries = '{10'd1023, 10'd0, 10'd1020, 10'd0};
        entries[3] = 10'($urandom_range(0, 1023));

        // Directed: operand extremes, every opcode but pop and halt, division corner cases.
        write_entry(entries[0]);
        send_instr(OP_PUSH, 32'h8000_0000);
        send_instr(OP_PUSH, 32'hFFFF_FFFF);
        send_instr(OP_DIV, 0);
        send_instr(OP_PUSH, 32'hFFFF_FFFF);
        send_instr(OP_MOD, 0);
        send_instr(OP_PUSH, 32'h7FFF_FFFF);
        for (op = OP_ADD; op <= OP_OR; op++)
        begin
            if (op == OP_NEG) send_instr(OP_NEG, 0);
            else
            begin
                send_instr(OP_PUSH, (op == OP_DIV || op == OP_MOD) ? 32'hFFFF_FFF9 : rand_value());
                send_instr(op, 0);
            end
        end
        send_instr(OP_CALL, 32'hFFFF_FFFF);
        send_instr(OP_STORE, 0);
        send_instr(OP_LOAD, -fb);
        send_instr(OP_PUSH, 0);
        send_instr(OP_JF, 32'h0000_0200);
        send_instr(OP_PUSH, 1);
        send_instr(OP_RET, 0);
        send_instr(OP_JMP, 32'hFFFF_FC05);
        send_instr(5'd31, 32'h5555_AAAA);

        // Random phases, each under a new entry_pc.
        for (int ph = 1; ph < 4; ph++)
        begin
            write_entry(entries[ph]);
            repeat (450) random_instr();
        end

        // Stop the block one way, then confirm it stays stopped.
        case ($urandom_range(0, 6))
            0:
            begin
                while (sp < 1024) send_instr(OP_PUSH, $urandom);
                send_instr(OP_PUSH, $urandom);
            end
            1:
            begin
                send_instr(OP_PUSH, $urandom);
                send_instr(OP_PUSH, 0);
                send_instr($urandom_range(0, 1) ? OP_DIV : OP_MOD, 0);
            end
            2: send_instr(OP_HALT, $urandom);
            3:
            begin
                if (sp == 0) send_instr(OP_PUSH, 1);
                send_instr(OP_STORE, -fb - 1);
            end
            4: send_instr(OP_LOAD, 1024 - fb);
            5:
            begin
                while (fc > 0)
                begin
                    if (sp == 0) send_instr(OP_PUSH, $urandom);
                    send_instr(OP_RET, 0);
                end
                send_instr(OP_PUSH, $urandom);
                send_instr(OP_RET, 0);
            end
            default:
            begin
                while (sp > 0) send_instr(OP_POP, 0);
                send_instr(OP_POP, 0);
            end
        endcase
        repeat (20) send_instr($urandom_range(0, 31), $urandom);
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/smx_pkg.sv
design/smx_div.sv
design/smx_dp.sv
design/smx_ctrl.sv
design/stack_machine_executor.sv
bench/stack_machine_executor_check.sv
bench/stack_machine_executor_test.sv
